// File: src/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion pipeline.
package rmq_pkg;

  localparam int DW        = 32;
  localparam int FRAC_BITS = 30;

  // trace, square-root argument and numerator widths
  localparam int TR_W  = DW + 2;
  localparam int ARG_W = DW + 1;
  localparam int NUM_W = DW + 1;

  // square root: two radicand bits per stage
  localparam int SQ_IN_W   = 2 * ((ARG_W + FRAC_BITS + 1) / 2);
  localparam int SQ_STAGES = SQ_IN_W / 2;
  localparam int ROOT_W    = SQ_STAGES;
  localparam int REM_W     = ROOT_W + 2;

  // divider: one quotient bit per stage
  localparam int MAG_W = NUM_W;
  localparam int N_W   = MAG_W + FRAC_BITS + 1;
  localparam int D_W   = ROOT_W + 1;
  localparam int QB    = DW;
  localparam int CMP_W = N_W + 2;
  localparam int LANES = 3;

  localparam int LATENCY = 1 + SQ_STAGES + 1 + 1 + QB + 1 + 1;

  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    SEL_W,
    SEL_X,
    SEL_Y,
    SEL_Z
  } sel_e;

  typedef logic signed [NUM_W-1:0] num_t;

  typedef struct packed {
    sel_e sel;
    num_t na;
    num_t nb;
    num_t nc;
  } side_t;

endpackage

// File: src/rmq_front.sv
// Front stage: trace, branch choice, square-root argument and numerators.
module rmq_front import rmq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [DW-1:0] m_11_i,
  input  logic signed [DW-1:0] m_12_i,
  input  logic signed [DW-1:0] m_13_i,
  input  logic signed [DW-1:0] m_21_i,
  input  logic signed [DW-1:0] m_22_i,
  input  logic signed [DW-1:0] m_23_i,
  input  logic signed [DW-1:0] m_31_i,
  input  logic signed [DW-1:0] m_32_i,
  input  logic signed [DW-1:0] m_33_i,
  output logic                 valid_o,
  output logic [ARG_W-1:0]     arg_o,
  output side_t                side_o
);

  logic signed [TR_W-1:0] e11, e22, e33, trace, arg_s, one_s;
  num_t d_w, d_y, d_z, s_xy, s_xz, s_yz;
  side_t side_d;
  logic valid_q;
  logic [ARG_W-1:0] arg_q;
  side_t side_q;

  assign e11   = TR_W'(m_11_i);
  assign e22   = TR_W'(m_22_i);
  assign e33   = TR_W'(m_33_i);
  assign one_s = TR_W'(ONE);
  assign trace = e11 + e22 + e33;

  assign d_w  = NUM_W'(m_32_i) - NUM_W'(m_23_i);
  assign d_y  = NUM_W'(m_13_i) - NUM_W'(m_31_i);
  assign d_z  = NUM_W'(m_21_i) - NUM_W'(m_12_i);
  assign s_xy = NUM_W'(m_12_i) + NUM_W'(m_21_i);
  assign s_xz = NUM_W'(m_13_i) + NUM_W'(m_31_i);
  assign s_yz = NUM_W'(m_23_i) + NUM_W'(m_32_i);

  always_comb begin
    if (trace > 0) begin
      side_d = '{sel: SEL_W, na: d_w, nb: d_y, nc: d_z};
      arg_s  = one_s + trace;
    end else if (e11 > e22 && e11 > e33) begin
      side_d = '{sel: SEL_X, na: d_w, nb: s_xy, nc: s_xz};
      arg_s  = one_s + e11 - e22 - e33;
    end else if (e22 > e33) begin
      side_d = '{sel: SEL_Y, na: d_y, nb: s_xy, nc: s_yz};
      arg_s  = one_s + e22 - e11 - e33;
    end else begin
      side_d = '{sel: SEL_Z, na: d_z, nb: s_xz, nc: s_yz};
      arg_s  = one_s + e33 - e11 - e22;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    arg_q  <= arg_s[TR_W-1] ? '0 : arg_s[ARG_W-1:0];
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign arg_o   = arg_q;
  assign side_o  = side_q;

endmodule

// File: src/rmq_sqrt.sv
// Pipelined square root, two radicand bits per stage, rounded to nearest.
module rmq_sqrt import rmq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [ARG_W-1:0]  arg_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);

  logic               vld_q  [SQ_STAGES];
  logic [SQ_IN_W-1:0] val_q  [SQ_STAGES];
  logic [REM_W-1:0]   rem_q  [SQ_STAGES];
  logic [ROOT_W-1:0]  root_q [SQ_STAGES];
  side_t              side_q [SQ_STAGES];

  logic              out_vld_q;
  logic [ROOT_W-1:0] out_root_q;
  side_t             out_side_q;

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_st
    logic               vld_p;
    logic [SQ_IN_W-1:0] val_p;
    logic [REM_W-1:0]   rem_p;
    logic [ROOT_W-1:0]  root_p;
    side_t              side_p;
    logic [REM_W+1:0]   rem2, trial;

    if (s == 0) begin : g_in
      assign vld_p  = valid_i;
      assign val_p  = SQ_IN_W'(arg_i) << FRAC_BITS;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
    end else begin : g_mid
      assign vld_p  = vld_q[s-1];
      assign val_p  = val_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign side_p = side_q[s-1];
    end

    assign rem2  = {rem_p, val_p[SQ_IN_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_p, 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rem2 >= trial) begin
        rem_q[s]  <= REM_W'(rem2 - trial);
        root_q[s] <= {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[s]  <= rem2[REM_W-1:0];
        root_q[s] <= {root_p[ROOT_W-2:0], 1'b0};
      end
      val_q[s]  <= val_p << 2;
      side_q[s] <= side_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[SQ_STAGES-1];
    end
  end

  // round up when the remainder exceeds the root
  always_ff @(posedge clk_i) begin
    out_root_q <= root_q[SQ_STAGES-1] +
                  ROOT_W'(rem_q[SQ_STAGES-1] > REM_W'(root_q[SQ_STAGES-1]));
    out_side_q <= side_q[SQ_STAGES-1];
  end

  assign valid_o = out_vld_q;
  assign root_o  = out_root_q;
  assign side_o  = out_side_q;

endmodule

// File: src/rmq_div.sv
// Three-lane pipelined divide by 2r, one quotient bit per stage, with saturation.
module rmq_div import rmq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [ROOT_W-1:0]    root_i,
  input  side_t                side_i,
  output logic                 valid_o,
  output sel_e                 sel_o,
  output logic [DW-1:0]        big_o,
  output logic signed [DW-1:0] qa_o,
  output logic signed [DW-1:0] qb_o,
  output logic signed [DW-1:0] qc_o
);

  // entry stage
  logic                         in_vld_q;
  logic [D_W-1:0]               in_d_q;
  logic [LANES-1:0][N_W-1:0]    in_n_q;
  logic [LANES-1:0]             in_neg_q;
  logic [DW-1:0]                in_big_q;
  sel_e                         in_sel_q;

  num_t                         num_in [LANES];
  logic [ROOT_W:0]              big_raw;

  // iteration stages
  logic                         vld_q [QB];
  logic [D_W-1:0]               d_q   [QB];
  logic [LANES-1:0][N_W-1:0]    rem_q [QB];
  logic [LANES-1:0][QB-1:0]     q_q   [QB];
  logic [LANES-1:0]             ovf_q [QB];
  logic [LANES-1:0]             neg_q [QB];
  logic [DW-1:0]                big_q [QB];
  sel_e                         sel_q [QB];

  logic                         out_vld_q;
  sel_e                         out_sel_q;
  logic [DW-1:0]                out_big_q;
  logic [LANES-1:0][DW-1:0]     out_q_q;

  assign num_in[0] = side_i.na;
  assign num_in[1] = side_i.nb;
  assign num_in[2] = side_i.nc;
  assign big_raw   = ((ROOT_W+1)'(root_i) + 1'b1) >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    in_d_q   <= (root_i == '0) ? D_W'(1) : {root_i, 1'b0};
    in_big_q <= (big_raw > (ROOT_W+1)'(ONE)) ? ONE : DW'(big_raw);
    in_sel_q <= side_i.sel;
    for (int l = 0; l < LANES; l++) begin
      in_neg_q[l] <= num_in[l][NUM_W-1];
      in_n_q[l]   <= (N_W'(num_in[l][NUM_W-1] ? MAG_W'(-num_in[l]) : MAG_W'(num_in[l]))
                      << FRAC_BITS) + N_W'(root_i);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_st
    localparam int B = QB - 1 - s;
    logic                      vld_p;
    logic [D_W-1:0]            d_p;
    logic [LANES-1:0][N_W-1:0] rem_p;
    logic [LANES-1:0][QB-1:0]  q_p;
    logic [LANES-1:0]          ovf_p;
    logic [LANES-1:0]          neg_p;
    logic [DW-1:0]             big_p;
    sel_e                      sel_p;
    logic [CMP_W-1:0]          dsh;
    logic [LANES-1:0][N_W-1:0] rem_n;
    logic [LANES-1:0][QB-1:0]  q_n;
    logic [LANES-1:0]          ovf_n;

    if (s == 0) begin : g_in
      assign vld_p = in_vld_q;
      assign d_p   = in_d_q;
      assign rem_p = in_n_q;
      assign q_p   = '0;
      assign neg_p = in_neg_q;
      assign big_p = in_big_q;
      assign sel_p = in_sel_q;
      // a quotient past the top bit only saturates
      for (genvar l = 0; l < LANES; l++) begin : g_ovf
        assign ovf_p[l] = CMP_W'(in_n_q[l]) >= (CMP_W'(in_d_q) << QB);
      end
    end else begin : g_mid
      assign vld_p = vld_q[s-1];
      assign d_p   = d_q[s-1];
      assign rem_p = rem_q[s-1];
      assign q_p   = q_q[s-1];
      assign ovf_p = ovf_q[s-1];
      assign neg_p = neg_q[s-1];
      assign big_p = big_q[s-1];
      assign sel_p = sel_q[s-1];
    end

    assign dsh = CMP_W'(d_p) << B;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        ovf_n[l] = ovf_p[l];
        q_n[l]   = q_p[l];
        rem_n[l] = rem_p[l];
        if (CMP_W'(rem_p[l]) >= dsh) begin
          rem_n[l]  = rem_p[l] - N_W'(dsh);
          q_n[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      d_q[s]   <= d_p;
      rem_q[s] <= rem_n;
      q_q[s]   <= q_n;
      ovf_q[s] <= ovf_n;
      neg_q[s] <= neg_p;
      big_q[s] <= big_p;
      sel_q[s] <= sel_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [DW-1:0] mag;
    out_sel_q <= sel_q[QB-1];
    out_big_q <= big_q[QB-1];
    for (int l = 0; l < LANES; l++) begin
      mag = (ovf_q[QB-1][l] || q_q[QB-1][l] > QB'(ONE)) ? ONE : DW'(q_q[QB-1][l]);
      out_q_q[l] <= neg_q[QB-1][l] ? -mag : mag;
    end
  end

  assign valid_o = out_vld_q;
  assign sel_o   = out_sel_q;
  assign big_o   = out_big_q;
  assign qa_o    = out_q_q[0];
  assign qb_o    = out_q_q[1];
  assign qc_o    = out_q_q[2];

endmodule

// File: src/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to quaternion converter, top level.
// Takes one 3x3 matrix per clock cycle in signed Q2.30 and returns x, y, z, w
// in Q2.30, each saturated to [-1.0, +1.0]. Every accepted matrix gives exactly
// one result, strobed by done_o for one cycle. From the start_i transfer, each
// matrix passes one front stage, 32 square-root stages plus rounding, one
// divider setup stage, 32 divider stages, a saturation stage and the output
// register. busy_o stays low, so a new matrix may be started every cycle; the
// receiver cannot stall and must take each result in its done_o cycle.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [DW-1:0] m_11_i,
  input  logic signed [DW-1:0] m_12_i,
  input  logic signed [DW-1:0] m_13_i,
  input  logic signed [DW-1:0] m_21_i,
  input  logic signed [DW-1:0] m_22_i,
  input  logic signed [DW-1:0] m_23_i,
  input  logic signed [DW-1:0] m_31_i,
  input  logic signed [DW-1:0] m_32_i,
  input  logic signed [DW-1:0] m_33_i,
  output logic                 done_o,
  output logic signed [DW-1:0] quat_x_o,
  output logic signed [DW-1:0] quat_y_o,
  output logic signed [DW-1:0] quat_z_o,
  output logic signed [DW-1:0] quat_w_o
);

  logic              fr_vld, sq_vld, dv_vld;
  logic [ARG_W-1:0]  fr_arg;
  side_t             fr_side, sq_side;
  logic [ROOT_W-1:0] sq_root;
  sel_e              dv_sel;
  logic [DW-1:0]     dv_big;
  logic signed [DW-1:0] dv_a, dv_b, dv_c;
  logic signed [DW-1:0] x_d, y_d, z_d, w_d;
  logic              done_q;
  logic signed [DW-1:0] x_q, y_q, z_q, w_q;

  assign busy_o = 1'b0;

  rmq_front u_front (
    .clk_i, .rst_ni,
    .valid_i (start_i && !busy_o),
    .m_11_i, .m_12_i, .m_13_i,
    .m_21_i, .m_22_i, .m_23_i,
    .m_31_i, .m_32_i, .m_33_i,
    .valid_o (fr_vld),
    .arg_o   (fr_arg),
    .side_o  (fr_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (fr_vld),
    .arg_i   (fr_arg),
    .side_i  (fr_side),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  rmq_div u_div (
    .clk_i, .rst_ni,
    .valid_i (sq_vld),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (dv_vld),
    .sel_o   (dv_sel),
    .big_o   (dv_big),
    .qa_o    (dv_a),
    .qb_o    (dv_b),
    .qc_o    (dv_c)
  );

  // route the large component and the three quotients by branch
  always_comb begin
    case (dv_sel)
      SEL_W: begin
        w_d = dv_big; x_d = dv_a; y_d = dv_b; z_d = dv_c;
      end
      SEL_X: begin
        x_d = dv_big; w_d = dv_a; y_d = dv_b; z_d = dv_c;
      end
      SEL_Y: begin
        y_d = dv_big; w_d = dv_a; x_d = dv_b; z_d = dv_c;
      end
      default: begin
        z_d = dv_big; w_d = dv_a; x_d = dv_b; y_d = dv_c;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    w_q <= w_d;
  end

  assign done_o   = done_q;
  assign quat_x_o = x_q;
  assign quat_y_o = y_q;
  assign quat_z_o = z_q;
  assign quat_w_o = w_q;

endmodule

// File: src/rmq_chk.sv
// Port-level checker for the quaternion converter, bound to the top level.
module rmq_chk import rmq_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic                 done_o,
  input logic signed [DW-1:0] quat_x_o,
  input logic signed [DW-1:0] quat_y_o,
  input logic signed [DW-1:0] quat_z_o,
  input logic signed [DW-1:0] quat_w_o
);

  localparam logic signed [DW-1:0] POS_ONE = ONE;
  localparam logic signed [DW-1:0] NEG_ONE = -ONE;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("accepted matrix gave no result at the fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result strobe without a matching start transfer");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> quat_x_o <= POS_ONE && quat_x_o >= NEG_ONE &&
               quat_y_o <= POS_ONE && quat_y_o >= NEG_ONE &&
               quat_z_o <= POS_ONE && quat_z_o >= NEG_ONE &&
               quat_w_o <= POS_ONE && quat_w_o >= NEG_ONE)
    else $error("quaternion component outside saturation range");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised on a fully pipelined converter");

endmodule

bind rotation_matrix_to_quaternion_top rmq_chk u_rmq_chk (.*);

// File: tb/sv/rotation_matrix_to_quaternion_checker.sv
// Result checker for the rotation matrix to quaternion block: predicts and compares.
module rotation_matrix_to_quaternion_checker import rmq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic signed [DW-1:0] m_11_i,
  input  logic signed [DW-1:0] m_12_i,
  input  logic signed [DW-1:0] m_13_i,
  input  logic signed [DW-1:0] m_21_i,
  input  logic signed [DW-1:0] m_22_i,
  input  logic signed [DW-1:0] m_23_i,
  input  logic signed [DW-1:0] m_31_i,
  input  logic signed [DW-1:0] m_32_i,
  input  logic signed [DW-1:0] m_33_i,
  input  logic                 done_i,
  input  logic signed [DW-1:0] quat_x_i,
  input  logic signed [DW-1:0] quat_y_i,
  input  logic signed [DW-1:0] quat_z_i,
  input  logic signed [DW-1:0] quat_w_i,
  output int                   err_cnt_o,
  output int                   pending_o
);

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] w;
  } quat_t;

  quat_t quat_q[$];

  function automatic longint unsigned root_round(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (v > res) res = res + 1;
    return res;
  endfunction

  function automatic longint clamp_one(longint v);
    longint one;
    one = longint'(1) << FRAC_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  // round half away from zero on the magnitude, then restore the sign
  function automatic longint scaled_ratio(longint num, longint unsigned r);
    longint unsigned d, mag, q;
    d   = r << 1;
    mag = (num < 0) ? longint'(-num) : num;
    if (d == 0) d = 1;
    q = ((mag << FRAC_BITS) + r) / d;
    return clamp_one((num < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic quat_t to_quat(longint a11, longint a12, longint a13,
                                    longint a21, longint a22, longint a23,
                                    longint a31, longint a32, longint a33);
    longint          one, tr, arg, big;
    longint unsigned r;
    sel_e            sel;
    quat_t           q;
    one = longint'(1) << FRAC_BITS;
    tr  = a11 + a22 + a33;
    if (tr > 0) begin
      sel = SEL_W;
      arg = one + tr;
    end else if (a11 > a22 && a11 > a33) begin
      sel = SEL_X;
      arg = one + a11 - a22 - a33;
    end else if (a22 > a33) begin
      sel = SEL_Y;
      arg = one + a22 - a11 - a33;
    end else begin
      sel = SEL_Z;
      arg = one + a33 - a11 - a22;
    end
    if (arg < 0) arg = 0;
    r   = root_round(longint'(arg) << FRAC_BITS);
    big = clamp_one(longint'((r + 1) >> 1));
    case (sel)
      SEL_W: begin
        q.w = DW'(big);
        q.x = DW'(scaled_ratio(a32 - a23, r));
        q.y = DW'(scaled_ratio(a13 - a31, r));
        q.z = DW'(scaled_ratio(a21 - a12, r));
      end
      SEL_X: begin
        q.x = DW'(big);
        q.w = DW'(scaled_ratio(a32 - a23, r));
        q.y = DW'(scaled_ratio(a12 + a21, r));
        q.z = DW'(scaled_ratio(a13 + a31, r));
      end
      SEL_Y: begin
        q.y = DW'(big);
        q.w = DW'(scaled_ratio(a13 - a31, r));
        q.x = DW'(scaled_ratio(a12 + a21, r));
        q.z = DW'(scaled_ratio(a23 + a32, r));
      end
      default: begin
        q.z = DW'(big);
        q.w = DW'(scaled_ratio(a21 - a12, r));
        q.x = DW'(scaled_ratio(a13 + a31, r));
        q.y = DW'(scaled_ratio(a23 + a32, r));
      end
    endcase
    return q;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH %s", msg);
    err_cnt_o++;
  endtask

  always @(posedge clk_i) begin
    quat_t e;
    if (!rst_ni) begin
      err_cnt_o = 0;
      pending_o = 0;
      quat_q.delete();
    end else begin
      if (done_i) begin
        if (quat_q.size() == 0) begin
          report_mismatch("result with no matrix outstanding");
        end else begin
          e = quat_q.pop_front();
          if (quat_x_i !== e.x)
            report_mismatch($sformatf("quat_x: got %h expected %h", quat_x_i, e.x));
          if (quat_y_i !== e.y)
            report_mismatch($sformatf("quat_y: got %h expected %h", quat_y_i, e.y));
          if (quat_z_i !== e.z)
            report_mismatch($sformatf("quat_z: got %h expected %h", quat_z_i, e.z));
          if (quat_w_i !== e.w)
            report_mismatch($sformatf("quat_w: got %h expected %h", quat_w_i, e.w));
        end
      end
      if (start_i && !busy_i)
        quat_q.push_back(to_quat(longint'(m_11_i), longint'(m_12_i), longint'(m_13_i),
                                 longint'(m_21_i), longint'(m_22_i), longint'(m_23_i),
                                 longint'(m_31_i), longint'(m_32_i), longint'(m_33_i)));
      pending_o = quat_q.size();
    end
  end

endmodule

// File: tb/sv/rotation_matrix_to_quaternion_top_tb.sv
// Testbench top for the rotation matrix to quaternion block: stimulus and verdict.
module rotation_matrix_to_quaternion_top_tb;
  import rmq_pkg::*;

  localparam int WATCHDOG = 2000;
  localparam int RAND_ITEMS = 1400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic signed [DW-1:0] m_i [9];
  logic                 done_o;
  logic signed [DW-1:0] quat_x_o, quat_y_o, quat_z_o, quat_w_o;
  int                   err_cnt;
  int                   pending;
  int                   idle_pct;
  int                   quiet_cycles;

  rotation_matrix_to_quaternion_top u_top (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .m_11_i(m_i[0]), .m_12_i(m_i[1]), .m_13_i(m_i[2]),
    .m_21_i(m_i[3]), .m_22_i(m_i[4]), .m_23_i(m_i[5]),
    .m_31_i(m_i[6]), .m_32_i(m_i[7]), .m_33_i(m_i[8]),
    .done_o, .quat_x_o, .quat_y_o, .quat_z_o, .quat_w_o
  );

  rotation_matrix_to_quaternion_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .m_11_i(m_i[0]), .m_12_i(m_i[1]), .m_13_i(m_i[2]),
    .m_21_i(m_i[3]), .m_22_i(m_i[4]), .m_23_i(m_i[5]),
    .m_31_i(m_i[6]), .m_32_i(m_i[7]), .m_33_i(m_i[8]),
    .done_i(done_o), .quat_x_i(quat_x_o), .quat_y_i(quat_y_o),
    .quat_z_i(quat_z_o), .quat_w_i(quat_w_o),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // count cycles in which nothing transfers on either side; end the run at WATCHDOG
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // value from a random 32-bit pattern, near +1.0 or -1.0 in Q2.30, or within [-1.0, +1.0]
  function automatic logic [DW-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return ONE - $urandom_range(0, 3);
      2:       return -ONE + $urandom_range(0, 3);
      3:       return {$urandom_range(0, 1) ? 2'b11 : 2'b00, 30'($urandom)};
      default: return $signed(DW'($urandom_range(0, 2 * ONE))) - $signed(ONE);
    endcase
  endfunction

  // rotation-like matrix: cyclic axis permutation with signs, (0,0) toggled for p >= 3, plus small noise
  task automatic fill_rotation();
    int p, s;
    logic signed [DW-1:0] v;
    p = $urandom_range(0, 5);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        s = (c == ((r + p) % 3)) ^ (p >= 3 && r == 0 && c == 0);
        v = $signed(DW'($urandom_range(0, 1 << 26))) - (1 << 25);
        if (s) v = $urandom_range(0, 1) ? ONE - $urandom_range(0, 1 << 24)
                                         : -ONE + $urandom_range(0, 1 << 24);
        m_i[3 * r + c] = v;
      end
  endtask

  task automatic send_matrix();
    start_i = 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    // hold start only when the next item goes out back to back
    if ($urandom_range(1, 100) <= idle_pct) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic load(int a11, int a12, int a13, int a21, int a22, int a23,
                      int a31, int a32, int a33);
    m_i = '{a11, a12, a13, a21, a22, a23, a31, a32, a33};
    send_matrix();
  endtask

  initial begin
    int o;
    rst_ni = 1'b0;
    start_i = 1'b0;
    idle_pct = 0;
    foreach (m_i[k]) m_i[k] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    o = ONE;
    // identity and each branch, ties between diagonals, zero trace
    load(o, 0, 0, 0, o, 0, 0, 0, o);
    load(o, 0, 0, 0, -o, 0, 0, 0, -o);
    load(-o, 0, 0, 0, o, 0, 0, 0, -o);
    load(-o, 0, 0, 0, -o, 0, 0, 0, o);
    load(0, 0, 0, 0, 0, 0, 0, 0, 0);
    load(-o, 0, 0, 0, -o, 0, 0, 0, -o);
    load(0, -o, 0, o, 0, 0, 0, 0, o);
    load(o, 0, 0, 0, 0, -o, 0, o, 0);
    load(o / 2, 0, 0, 0, o / 2, 0, 0, 0, -o);
    load(o, 0, 0, 0, -o / 2, 0, 0, 0, -o / 2);
    load(-o, o, o, o, 0, o, o, o, 0);
    // field extremes, including non-rotation inputs that saturate
    load(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
         32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    load(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
         32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    load(-1, -1, -1, -1, -1, -1, -1, -1, -1);
    load(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000);
    load(-o, 32'h7fffffff, 32'h80000000, 32'h80000000, -o, 32'h7fffffff,
         32'h7fffffff, 32'h80000000, -o);
    load(1, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      case ((i * 4) / RAND_ITEMS)
        0: idle_pct = 0;
        1: idle_pct = 46;
        2: idle_pct = 18;
        default: idle_pct = (i % 200 < 100) ? 0 : 46;
      endcase
      if ($urandom_range(1, 100) <= 70) fill_rotation();
      else foreach (m_i[k]) m_i[k] = rand_elem();
      send_matrix();
    end
    start_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
